// File: sv/fsla_pkg.sv
// Shared types, codes and helpers for the fixed-slot free-list allocator.
// No dependencies; every other file in this folder imports it.
package fsla_pkg;

  localparam int CFG_W    = 32;  // configuration write data
  localparam int CFG_IDX_W = 2;  // configuration register index
  localparam int ADDR_W   = 32;
  localparam int OBJ_W    = 13;  // requested object size
  localparam int SIZE_W   = 14;  // rounded slot size, up to 8192
  localparam int CNT_W    = 11;  // slot count, capacity and in-use count
  localparam int SPAN_W   = 25;  // slot size times capacity
  localparam int STEP_W   = 4;   // divider step counter

  localparam logic [CNT_W-1:0]    COUNT_MAX  = 11'd2047;
  localparam logic [STEP_W-1:0]   STEP_FIRST = 4'd10;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_REBUILD = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY      = 2'd1;
  localparam logic [1:0] ST_RANGE      = 2'd2;
  localparam logic [1:0] ST_MISALIGNED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] ptr;
  } alloc_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] slot_address;
    logic [1:0]        status;
    logic [CNT_W-1:0]  in_use;
  } alloc_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;      // latch the accepted transaction, clear the result
    logic pop_start;    // read the head link, form head * size
    logic pop_finish;   // advance the head, form the slot address
    logic set_empty;
    logic set_range;
    logic div_start;
    logic div_step;
    logic push;         // check the remainder, push the slot if aligned
    logic build_start;  // latch the live geometry, reset head and count
    logic build_step;   // write one link of the rebuilt list
    logic load_out;     // move the result into the output register
  } fsla_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] func;
    logic       list_empty;
    logic       ptr_bad;
    logic       cap_zero;
    logic       build_last;
    logic       div_last;
  } fsla_stat_t;

  // Round a requested size up to a multiple of eight, at least eight
  function automatic logic [SIZE_W-1:0] round_size(input logic [OBJ_W-1:0] req);
    logic [SIZE_W-1:0] r;
    r = (req < OBJ_W'(8)) ? SIZE_W'(8) : {1'b0, req};
    return (r + SIZE_W'(7)) & ~SIZE_W'(7);
  endfunction

endpackage

// File: sv/fsla_datapath.sv
// Datapath of the free-list allocator: configuration and live geometry,
// the link memory, the head and count registers, the divider and the output register.
// Depends on fsla_pkg.
module fsla_datapath import fsla_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  alloc_in_t            in_data,
  input  fsla_cmd_t            cmd,
  output fsla_stat_t           stat,
  output alloc_out_t           out_data
);

  localparam int LINK_W = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CAP_MAX = (MAX_SLOTS > 2047) ? 2047 : MAX_SLOTS;
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_SLOTS);

  // configuration registers
  logic [ADDR_W-1:0] base_address;
  logic [OBJ_W-1:0]  object_size;
  logic [CNT_W-1:0]  slot_count;

  // live geometry, latched at rebuild
  logic [ADDR_W-1:0] live_base;
  logic [SIZE_W-1:0] live_size;
  logic [CNT_W-1:0]  live_cap;
  logic [SPAN_W-1:0] span;

  logic [1:0]        cur_func;
  logic [ADDR_W-1:0] cur_ptr;
  logic [LINK_W-1:0] head;
  logic [CNT_W-1:0]  count;
  logic [SPAN_W-1:0] prod;
  logic [ADDR_W-1:0] res_addr;
  logic [1:0]        res_status;

  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] dvs;
  logic [CNT_W-1:0]  quo;
  logic [STEP_W-1:0] step_k;
  logic [CNT_W-1:0]  walk;

  logic [LINK_W-1:0] link_mem [MAX_SLOTS];
  logic [LINK_W-1:0] rd_data;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [LINK_W-1:0] mem_wdata;

  logic [ADDR_W-1:0] offset;
  logic [CNT_W-1:0]  cap_next;
  logic [LINK_W-1:0] link_next;
  logic              aligned;
  logic [CNT_W:0]    walk_inc;

  assign offset   = cur_ptr - live_base;
  assign cap_next = ({21'b0, slot_count} > 32'(CAP_MAX)) ? CNT_W'(CAP_MAX) : slot_count;
  assign link_next = (rd_data >= END_MARK) ? END_MARK : rd_data;
  assign aligned  = (rem == '0);
  assign walk_inc = {1'b0, walk} + 1'b1;

  assign stat.func       = cur_func;
  assign stat.list_empty = (head >= END_MARK);
  assign stat.ptr_bad    = (cur_ptr == '0) || (offset >= {7'b0, span});
  assign stat.cap_zero   = (live_cap == '0);
  assign stat.build_last = (walk_inc >= {1'b0, live_cap});
  assign stat.div_last   = (step_k == '0);

  // link memory write port: rebuild walk or a push
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = IDX_W'(walk);
    mem_wdata = stat.build_last ? END_MARK : LINK_W'(walk_inc);
    if (cmd.push && aligned) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(quo);
      mem_wdata = head;
    end else if (cmd.build_step) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= link_mem[head[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      object_size  <= OBJ_W'(8);
      slot_count   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS: base_address <= cfg_data;
        REG_OBJECT_SIZE:  object_size  <= cfg_data[OBJ_W-1:0];
        REG_SLOT_COUNT:   slot_count   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // state registers that reset defines
  always_ff @(posedge clk) begin
    if (rst) begin
      live_base <= '0;
      live_size <= SIZE_W'(8);
      live_cap  <= '0;
      head      <= END_MARK;
      count     <= '0;
    end else begin
      if (cmd.build_start) begin
        live_base <= base_address;
        live_size <= round_size(object_size);
        live_cap  <= cap_next;
        head      <= (cap_next != '0) ? '0 : END_MARK;
        count     <= '0;
      end
      if (cmd.pop_finish) begin
        head <= link_next;
        if (count != COUNT_MAX) begin
          count <= count + 1'b1;
        end
      end
      if (cmd.push && aligned) begin
        head <= LINK_W'(quo);
        if (count != '0) begin
          count <= count - 1'b1;
        end
      end
    end
  end

  // working registers: no reset needed
  always_ff @(posedge clk) begin
    span <= SPAN_W'(live_size) * SPAN_W'(live_cap);
    if (cmd.capture) begin
      cur_func   <= in_data.func;
      cur_ptr    <= in_data.ptr;
      res_addr   <= '0;
      res_status <= ST_OK;
    end
    if (cmd.pop_start) begin
      prod <= SPAN_W'(head) * SPAN_W'(live_size);
    end
    if (cmd.pop_finish) begin
      res_addr <= live_base + ADDR_W'(prod);
    end
    if (cmd.set_empty) begin
      res_status <= ST_EMPTY;
    end
    if (cmd.set_range) begin
      res_status <= ST_RANGE;
    end
    if (cmd.push && !aligned) begin
      res_status <= ST_MISALIGNED;
    end
    if (cmd.div_start) begin
      rem    <= offset[SPAN_W-1:0];
      dvs    <= {1'b0, live_size, 10'b0};
      quo    <= '0;
      step_k <= STEP_FIRST;
    end
    if (cmd.div_step) begin
      // one restoring step: subtract the shifted divisor where it fits
      if (rem >= dvs) begin
        rem <= rem - dvs;
        quo <= {quo[CNT_W-2:0], 1'b1};
      end else begin
        quo <= {quo[CNT_W-2:0], 1'b0};
      end
      dvs    <= dvs >> 1;
      step_k <= step_k - 1'b1;
    end
    if (cmd.build_start) begin
      walk <= '0;
    end
    if (cmd.build_step) begin
      walk <= walk + 1'b1;
    end
    if (cmd.load_out) begin
      out_data.slot_address <= res_addr;
      out_data.status       <= res_status;
      out_data.in_use       <= count;
    end
  end

endmodule

// File: sv/fsla_ctrl.sv
// Controller of the free-list allocator: sequences one transaction at a time
// and owns the input and output handshakes. Depends on fsla_pkg.
module fsla_ctrl import fsla_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  fsla_stat_t stat,
  output fsla_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_ALLOC  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FREE   = 3'd4;
  localparam logic [2:0] S_BUILD  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        priority case (stat.func)
          FUNC_ALLOC: begin
            if (stat.list_empty) begin
              cmd.set_empty = 1'b1;
              state_next    = S_DONE;
            end else begin
              cmd.pop_start = 1'b1;
              state_next    = S_ALLOC;
            end
          end
          FUNC_FREE: begin
            if (stat.ptr_bad) begin
              cmd.set_range = 1'b1;
              state_next    = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          FUNC_REBUILD: begin
            cmd.build_start = 1'b1;
            state_next      = S_BUILD;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_ALLOC: begin
        cmd.pop_finish = 1'b1;
        state_next     = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_FREE;
        end
      end
      S_FREE: begin
        cmd.push   = 1'b1;
        state_next = S_DONE;
      end
      S_BUILD: begin
        // capacity is live from this cycle on
        if (stat.cap_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.build_step = 1'b1;
          if (stat.build_last) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/fixed_slot_free_list_allocator.sv
// Fixed-slot free-list allocator: top level joining controller and datapath.
// Depends on fsla_pkg, fsla_ctrl and fsla_datapath.
//
// Hands out equal slots of a region that starts at base_address. The slot size is
// object_size rounded up to a multiple of eight (at least eight); slot_count, capped at
// MAX_SLOTS, sets the capacity. base_address, object_size and slot_count take effect only
// at the next rebuild transaction, which links every slot into a free list in ascending
// order and clears the in-use count. Allocate pops the head slot and returns its address
// (status 1 and address zero when the pool is empty); free checks the pointer and pushes its
// slot back (status 2 for null or out of range, 3 for a pointer off a slot boundary, both
// ignored). Double frees are not detected. Every transaction gives exactly one result.
// One transaction is in flight at a time; a finished result waits in the output register
// while the next transaction is accepted. After acceptance the controller decodes the
// transaction; an allocate then pops the head slot, a rejected or unused-code transaction
// goes straight to the result, an accepted free runs eleven steps of the one-bit restoring
// divider that turns the offset into a slot index and then pushes, and a rebuild writes
// capacity links (one link memory write a cycle, none for zero capacity). The controller
// returns to idle before it accepts the next transaction; a result still waiting when the next
// one is ready holds the controller until it is taken. The link memory is not cleared
// after reset: entries are read only once the rebuild walk or a free has written them.
module fixed_slot_free_list_allocator import fsla_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  alloc_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output alloc_out_t           out_data
);

  fsla_cmd_t  cmd;
  fsla_stat_t stat;

  // sequence each transaction and own both handshakes
  fsla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // hold configuration, list memory, counters, divider and output register
  fsla_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // one transaction at a time: no acceptance straight after another
  a_single_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("transaction accepted while another is in flight");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // any non-ok result carries a zero address
  a_err_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |-> (out_data.slot_address == '0))
    else $error("error result with non-zero address");

  // a pop and a push never happen together
  a_pop_push_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.pop_finish && cmd.push))
    else $error("pop and push in the same cycle");

endmodule
